// File: rtl/position_speed_estimator_defines.svh
// assertion macros for the position speed estimator
// no dependencies
`ifndef POSITION_SPEED_ESTIMATOR_DEFINES_SVH
`define POSITION_SPEED_ESTIMATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define PSE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define PSE_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define PSE_ASSERT(label, clk, rst_n, prop)
`define PSE_ASSERT_NR(label, clk, prop)
`endif
`endif

// File: rtl/pse_pkg.sv
// shared types and constants of the position speed estimator
// no dependencies
package pse_pkg;
    localparam int WINDOW_MAX_DEF = 16;
    localparam logic [1:0] REG_MIN_DT   = 2'd0;
    localparam logic [1:0] REG_WIN_LEN  = 2'd1;
    localparam logic [1:0] REG_FLOOR    = 2'd2;
    localparam logic [1:0] REG_MAX_SPD  = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;     // register the input beat
        logic store_prev;  // copy sample into previous
        logic sqrt_init;
        logic sqrt_step;
        logic mul_step;
        logic div_init;
        logic div_step;
        logic win_read;    // read oldest entry
        logic win_update;  // write new entry, update sum and fill
        logic avg_init;
        logic avg_step;
        logic out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic short_gap;
        logic have_prev;
    } t_sts;
endpackage

// File: rtl/pse_datapath.sv
// datapath: deltas, bit-serial square root, multiply, divides and window memory
// depends on pse_pkg and position_speed_estimator_defines.svh
`include "position_speed_estimator_defines.svh"
module pse_datapath #(
    parameter int WINDOW_MAX = pse_pkg::WINDOW_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pse_pkg::t_cmd      i_cmd,
    output pse_pkg::t_sts      o_sts,
    input  logic signed [19:0] i_pos_x,
    input  logic signed [19:0] i_pos_y,
    input  logic [31:0]        i_stamp_us,
    input  logic [19:0]        i_min_dt,
    input  logic [4:0]         i_win_len,
    input  logic [15:0]        i_floor,
    input  logic [15:0]        i_max_spd,
    output logic [15:0]        o_speed
);
    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int FW = $clog2(WINDOW_MAX + 1);
    localparam int SW = 16 + FW;

    logic               r_have_prev;
    logic signed [19:0] r_last_x, r_last_y, r_x, r_y;
    logic [31:0]        r_last_stamp, r_stamp;

    // gap and step deltas of the held beat
    logic [31:0]        w_dt;
    logic signed [20:0] w_dx, w_dy;
    logic [19:0]        w_min;
    assign w_dt  = r_stamp - r_last_stamp;
    assign w_dx  = 21'(r_x) - 21'(r_last_x);
    assign w_dy  = 21'(r_y) - 21'(r_last_y);
    assign w_min = (i_min_dt == 20'd0) ? 20'd1 : i_min_dt;
    assign o_sts.short_gap = w_dt < {12'd0, w_min};
    assign o_sts.have_prev = r_have_prev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev  <= 1'b0;
            r_last_x     <= '0;
            r_last_y     <= '0;
            r_last_stamp <= '0;
        end else if (i_cmd.store_prev) begin
            r_have_prev  <= 1'b1;
            r_last_x     <= r_x;
            r_last_y     <= r_y;
            r_last_stamp <= r_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x     <= i_pos_x;
            r_y     <= i_pos_y;
            r_stamp <= i_stamp_us;
        end
    end

    // radicand d2<<16 fits 57 bits; square root one result bit per cycle
    logic [61:0] r_rad;
    logic [31:0] r_root;
    logic [33:0] r_rem;
    logic [33:0] w_trial;
    logic [41:0] w_sq_x, w_sq_y;
    assign w_sq_x  = 42'($signed(w_dx) * $signed(w_dx));
    assign w_sq_y  = 42'($signed(w_dy) * $signed(w_dy));
    assign w_trial = {r_rem[31:0], r_rad[61:60]} - {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_init) begin
            r_rad  <= {3'd0, 43'(w_sq_x) + 43'(w_sq_y), 16'd0};
            r_root <= '0;
            r_rem  <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_rad <= {r_rad[59:0], 2'b00};
            if (!w_trial[33]) begin
                r_rem  <= w_trial;
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_rem  <= {r_rem[31:0], r_rad[61:60]};
                r_root <= {r_root[30:0], 1'b0};
            end
        end
    end

    // q * 10^9 by shift-add, 30 steps of the constant bits
    localparam logic [29:0] SCALE = 30'd1000000000;
    logic [61:0] r_prod;
    logic [4:0]  r_mcnt;
    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_init) begin
            r_prod <= '0;
            r_mcnt <= 5'd29;
        end else if (i_cmd.mul_step) begin
            r_prod <= {r_prod[60:0], 1'b0} + (SCALE[r_mcnt] ? {30'd0, r_root} : 62'd0);
            r_mcnt <= r_mcnt - 5'd1;
        end
    end

    // restoring divide: prod / (dt<<20), quotient saturated at 16 bits
    logic [62:0] r_dnum;
    logic [52:0] r_drem;
    logic [16:0] r_quo;
    logic        r_qovf;
    logic [53:0] w_dsub;
    logic        w_dfit;
    assign w_dsub = {r_drem, r_dnum[62]} - {2'd0, w_dt, 20'd0};
    assign w_dfit = !w_dsub[53];
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_dnum <= {1'b0, r_prod};
            r_drem <= '0;
            r_quo  <= '0;
            r_qovf <= 1'b0;
        end else if (i_cmd.div_step) begin
            r_dnum <= {r_dnum[61:0], 1'b0};
            r_drem <= w_dfit ? w_dsub[52:0] : {r_drem[51:0], r_dnum[62]};
            r_quo  <= {r_quo[15:0], w_dfit};
            r_qovf <= r_qovf | r_quo[16];
        end
    end
    logic [15:0] w_speed;
    assign w_speed = (r_qovf || r_quo[16]) ? 16'hFFFF : r_quo[15:0];

    // window memory, sum and fill
    logic [15:0] r_mem [WINDOW_MAX];
    logic [15:0] r_old;
    logic [AW-1:0] r_head;
    logic [FW-1:0] r_fill;
    logic [SW-1:0] r_sum;
    logic [FW-1:0] w_len;
    logic          w_drop;
    logic [AW:0]   w_oidx;
    assign w_len  = (i_win_len == 5'd0) ? FW'(1) :
                    ({27'd0, i_win_len} > WINDOW_MAX) ? FW'(WINDOW_MAX) : FW'(i_win_len);
    assign w_drop = r_fill >= w_len;
    assign w_oidx = ({1'b0, r_head} >= (AW+1)'(r_fill)) ?
                    (AW+1)'({1'b0, r_head} - (AW+1)'(r_fill)) :
                    (AW+1)'({1'b0, r_head} + (AW+1)'(WINDOW_MAX) - (AW+1)'(r_fill));

    always_ff @(posedge i_clk) begin
        if (i_cmd.win_read) r_old <= r_mem[w_oidx[AW-1:0]];
        if (i_cmd.win_update) r_mem[r_head] <= w_speed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
            r_sum  <= '0;
        end else if (i_cmd.win_update) begin
            r_head <= ({1'b0, r_head} + 1'b1 >= (AW+1)'(WINDOW_MAX)) ? '0 : r_head + 1'b1;
            r_sum  <= r_sum - (w_drop ? SW'(r_old) : SW'(0)) + SW'(w_speed);
            r_fill <= w_drop ? r_fill : r_fill + 1'b1;
        end
    end

    // average by restoring divide sum / fill, one bit per cycle
    logic [SW-1:0] r_anum;
    logic [FW-1:0] r_arem;
    logic [SW-1:0] r_aq;
    logic [FW:0]   w_asub;
    assign w_asub = {r_arem, r_anum[SW-1]} - {1'b0, r_fill};
    always_ff @(posedge i_clk) begin
        if (i_cmd.avg_init) begin
            r_anum <= r_sum;
            r_arem <= '0;
            r_aq   <= '0;
        end else if (i_cmd.avg_step) begin
            r_anum <= {r_anum[SW-2:0], 1'b0};
            r_arem <= !w_asub[FW] ? w_asub[FW-1:0] : {r_arem[FW-2:0], r_anum[SW-1]};
            r_aq   <= {r_aq[SW-2:0], !w_asub[FW]};
        end
    end

    // floor then clamp
    logic [15:0] w_avg, w_fl;
    assign w_avg = r_aq[15:0];
    assign w_fl  = (w_avg < i_floor) ? 16'd0 : w_avg;
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) o_speed <= (w_fl > i_max_spd) ? i_max_spd : w_fl;
    end

    `PSE_ASSERT(a_fill_bound, i_clk, i_rst_n, ({27'd0, r_fill} <= WINDOW_MAX))
    `PSE_ASSERT(a_fill_grows, i_clk, i_rst_n, (i_cmd.win_update && !w_drop |=> r_fill != 0))
    `PSE_ASSERT(a_prev_sticks, i_clk, i_rst_n, ($past(r_have_prev) |-> r_have_prev))
endmodule

// File: rtl/pse_ctrl.sv
// controller sequencing the datapath through one sample
// depends on pse_pkg and position_speed_estimator_defines.svh
`include "position_speed_estimator_defines.svh"
module pse_ctrl #(
    parameter int WINDOW_MAX = pse_pkg::WINDOW_MAX_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  pse_pkg::t_sts i_sts,
    output pse_pkg::t_cmd o_cmd
);
    localparam int FW = $clog2(WINDOW_MAX + 1);
    localparam int SW = 16 + FW;
    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_SQRT, S_MUL, S_DIV, S_WIN, S_AVG, S_OUT
    } t_state;

    t_state      r_state;
    logic [5:0]  r_cnt;
    logic        r_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd = '0;
        o_cmd.load_in = (r_state == S_IDLE) && i_in_valid;
        unique case (r_state)
            S_CHECK: begin
                o_cmd.store_prev = !i_sts.have_prev;
                o_cmd.sqrt_init  = i_sts.have_prev && !i_sts.short_gap;
            end
            S_SQRT:  o_cmd.sqrt_step = 1'b1;
            S_MUL: begin
                o_cmd.mul_step = (r_cnt != 6'd0);
                o_cmd.div_init = (r_cnt == 6'd0);
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                o_cmd.win_read = (r_cnt == 6'd0);
            end
            S_WIN: begin
                o_cmd.win_update = 1'b1;
            end
            S_AVG: begin
                o_cmd.avg_init   = (r_cnt == 6'(SW + 1));
                o_cmd.avg_step   = (r_cnt != 6'd0);
                o_cmd.out_load   = (r_cnt == 6'd0);
                o_cmd.store_prev = (r_cnt == 6'd0);
            end
            default: ;
        endcase
    end

    // div_init takes the product on the last multiply cycle, after all 30 constant bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_in_valid && !r_out_valid) r_state <= S_CHECK;
                S_CHECK: begin
                    if (i_sts.have_prev && !i_sts.short_gap) begin
                        r_state <= S_SQRT;
                        r_cnt   <= 6'd30;
                    end else r_state <= S_IDLE;
                end
                S_SQRT: begin
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        r_state <= S_MUL;
                        r_cnt   <= 6'd30;
                    end
                end
                S_MUL: begin
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        r_state <= S_DIV;
                        r_cnt   <= 6'd62;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) r_state <= S_WIN;
                end
                // average starts once sum and fill hold the new entry
                S_WIN: begin
                    r_state <= S_AVG;
                    r_cnt   <= 6'(SW + 1);
                end
                S_AVG: begin
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        r_state     <= S_OUT;
                        r_out_valid <= 1'b1;
                    end
                end
                S_OUT: if (i_out_ready) begin
                    r_out_valid <= 1'b0;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `PSE_ASSERT(a_out_only_done, i_clk, i_rst_n, (r_out_valid |-> r_state == S_OUT))
    `PSE_ASSERT(a_no_take_busy, i_clk, i_rst_n, (o_cmd.load_in |-> r_state == S_IDLE))
    `PSE_ASSERT(a_out_holds, i_clk, i_rst_n, (r_out_valid && !i_out_ready |=> r_out_valid))
endmodule

// File: rtl/position_speed_estimator.sv
// top level of the position speed estimator: config registers, controller, datapath
// depends on pse_pkg, pse_ctrl, pse_datapath
//  channel | direction | payload
//  s_axis  | in        | tdata: pos_x, pos_y, stamp_us
//  m_axis  | out       | tdata: speed_mm_s
//  cfg     | in        | index 2 bits, data 20 bits
// a sample that yields a speed passes, in order, through accept, check, bit-serial
// square root, shift-add multiply, divide, window update, average divide and load,
// and output; first or too-early samples pass only accept and check; no new sample
// is taken until the last is through, and the input waits while a result is held
// reset is synchronous active low, clears history and window, and sets config defaults
module position_speed_estimator #(
    parameter int WINDOW_MAX = pse_pkg::WINDOW_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // pos_x[19:0], pos_y[39:20], stamp_us[71:40]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // speed_mm_s[15:0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);
    logic [19:0] r_min_dt;
    logic [4:0]  r_win_len;
    logic [15:0] r_floor, r_max_spd;
    pse_pkg::t_cmd w_cmd;
    pse_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dt  <= 20'd1000;
            r_win_len <= 5'd10;
            r_floor   <= 16'd10;
            r_max_spd <= 16'd2500;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pse_pkg::REG_MIN_DT:  r_min_dt  <= i_cfg_data;
                pse_pkg::REG_WIN_LEN: r_win_len <= i_cfg_data[4:0];
                pse_pkg::REG_FLOOR:   r_floor   <= i_cfg_data[15:0];
                pse_pkg::REG_MAX_SPD: r_max_spd <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    pse_ctrl #(.WINDOW_MAX(WINDOW_MAX)) u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_sts(w_sts), .o_cmd(w_cmd)
    );

    pse_datapath #(.WINDOW_MAX(WINDOW_MAX)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_sts(w_sts),
        .i_pos_x(s_axis_tdata[19:0]), .i_pos_y(s_axis_tdata[39:20]),
        .i_stamp_us(s_axis_tdata[71:40]),
        .i_min_dt(r_min_dt), .i_win_len(r_win_len),
        .i_floor(r_floor), .i_max_spd(r_max_spd),
        .o_speed(m_axis_tdata)
    );
endmodule
